/* src/pem_pkg.sv */
// Shared types and constants for the Prewitt edge magnitude block.
// Used by the square-root unit and the top level; depends on nothing else.
`default_nettype none

package pem_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_OUT_W  = 10;
  localparam int unsigned WCFG_W     = 11;
  localparam int unsigned HCFG_W     = 12;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned MIN_DIM    = 3;

  localparam int unsigned GRAD_W     = 10;
  localparam int unsigned SUMSQ_W    = 21;
  localparam int unsigned ROOT_ACC_W = SUMSQ_W + 1;
  localparam int unsigned ROOT_STEPS = 11;
  localparam int unsigned STEP_W     = 4;

  localparam int unsigned EDGE_SCALE = 15;
  localparam int unsigned EDGE_MAX   = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 8'd0,
    CFG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SQUARE,
    SQ_ITER,
    SQ_DONE
  } sq_state_e;

  typedef struct packed {
    logic start;
    logic take;
  } sq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_status_t;

endpackage

`default_nettype wire

/* src/pem_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module pem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/pem_isqrt.sv */
// Iterative gradient magnitude unit: squares two gradients, takes the floor
// square root one bit per cycle, then scales and saturates. Uses pem_pkg.
`default_nettype none

module pem_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pem_pkg::sq_ctrl_t             ctrl_i,
  input  wire logic [pem_pkg::GRAD_W-1:0]    av_i,
  input  wire logic [pem_pkg::GRAD_W-1:0]    ah_i,
  output pem_pkg::sq_status_t                status_o,
  output logic      [pem_pkg::PIX_W-1:0]     edge_o
);
  import pem_pkg::*;

  sq_state_e               state_q, state_d;
  logic [GRAD_W-1:0]       av_q, ah_q;
  logic [SUMSQ_W-1:0]      rem_q;
  logic [ROOT_ACC_W-1:0]   root_q;
  logic [STEP_W-1:0]       step_q;
  logic [ROOT_ACC_W-1:0]   bit_w;
  logic [ROOT_ACC_W-1:0]   trial;
  logic                    fits;

  assign bit_w = ROOT_ACC_W'(1) << {step_q, 1'b0};
  assign trial = root_q + bit_w;
  assign fits  = {1'b0, rem_q} >= trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE:   if (ctrl_i.start) state_d = SQ_SQUARE;
      SQ_SQUARE: state_d = SQ_ITER;
      SQ_ITER:   if (step_q == '0) state_d = SQ_DONE;
      SQ_DONE:   if (ctrl_i.take) state_d = SQ_IDLE;
      default:   state_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    status_o.busy = (state_q != SQ_IDLE);
    status_o.done = (state_q == SQ_DONE);
    if (root_q > ROOT_ACC_W'(EDGE_MAX / EDGE_SCALE)) begin
      edge_o = PIX_W'(EDGE_MAX);
    end else begin
      edge_o = PIX_W'(9'(root_q[4:0]) * 9'(EDGE_SCALE));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SQ_IDLE: begin
        av_q <= av_i;
        ah_q <= ah_i;
      end
      SQ_SQUARE: begin
        rem_q  <= SUMSQ_W'((2*GRAD_W)'(av_q) * (2*GRAD_W)'(av_q)) +
                  SUMSQ_W'((2*GRAD_W)'(ah_q) * (2*GRAD_W)'(ah_q));
        root_q <= '0;
        step_q <= STEP_W'(ROOT_STEPS - 1);
      end
      SQ_ITER: begin
        if (fits) begin
          rem_q  <= SUMSQ_W'({1'b0, rem_q} - trial);
          root_q <= (root_q >> 1) + bit_w;
        end else begin
          root_q <= root_q >> 1;
        end
        step_q <= step_q - 1'b1;
      end
      SQ_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/prewitt_edge_magnitude.sv */
// Top level of the Prewitt 3x3 gradient magnitude block.
// Uses pem_pkg, pem_ram for the two line stores and pem_isqrt for the magnitude.
//
// Grey pixels stream in raster order; the two previous rows sit side by side in
// one 16-bit wide RAM indexed by column, and six registers hold the window.
// Border pixels pass at one item per cycle while no interior pixel is pending,
// and give no result. An interior pixel holds off the next item until its
// result is handed over: the line stores are read, the window is formed, then
// the square-root unit squares, finds 11 root bits and hands over to the output
// register once it is free. The line stores need no clearing pass after reset.
// Writing a configuration register restarts the frame at row 0, column 0.
`default_nettype none

module prewitt_edge_magnitude #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [pem_pkg::PIX_W-1:0]          gray_pixel_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [pem_pkg::PIX_W-1:0]          edge_value_o,
  output logic      [pem_pkg::ROW_W-1:0]          center_row_o,
  output logic      [pem_pkg::COL_OUT_W-1:0]      center_col_o,
  output logic                                    frame_last_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pem_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [pem_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pem_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  = (WEFF_W > WCFG_W) ? WEFF_W : WCFG_W;
  localparam int unsigned COLX_W = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;

  logic [WCFG_W-1:0]  wcfg_q;
  logic [HCFG_W-1:0]  hcfg_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;

  logic [CMP_W-1:0]   w_eff;
  logic [HCFG_W-1:0]  h_eff;
  logic               col_last, row_last, interior;
  logic               accept, cfg_hit;
  logic [COLX_W-1:0]  col_ext;

  logic               s1_vld_q, s1_int_q, s1_last_q;
  logic [PIX_W-1:0]   s1_pix_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [COL_OUT_W-1:0] s1_ccol_q;

  logic [2*PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0]   up, mid;
  logic [PIX_W-1:0]   win_q [6];

  logic [PIX_W+1:0]   sum_top, sum_bot, sum_left, sum_right;
  logic signed [PIX_W+2:0] gv, gh;
  logic [GRAD_W-1:0]  av, ah;

  logic [ROW_W-1:0]     m_row_q;
  logic [COL_OUT_W-1:0] m_col_q;
  logic                 m_last_q;

  sq_ctrl_t           sq_ctrl;
  sq_status_t         sq_status;
  logic [PIX_W-1:0]   sq_edge;

  logic               out_vld_q, out_load;
  logic [PIX_W-1:0]   out_edge_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic               out_last_q;

  always_comb begin
    if (CMP_W'(wcfg_q) < CMP_W'(MIN_DIM)) begin
      w_eff = CMP_W'(MIN_DIM);
    end else if (CMP_W'(wcfg_q) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(wcfg_q);
    end
    h_eff = (hcfg_q < HCFG_W'(MIN_DIM)) ? HCFG_W'(MIN_DIM) : hcfg_q;
  end

  assign col_last = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
  assign row_last = ({1'b0, row_q} + 13'd1) >= {1'b0, h_eff};
  assign interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
  assign col_ext  = COLX_W'(col_q) - COLX_W'(1);

  assign in_stall_o  = sq_status.busy | (s1_vld_q & s1_int_q);
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i &&
                       (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcfg_q <= WCFG_W'(640);
      hcfg_q <= HCFG_W'(480);
      col_q  <= '0;
      row_q  <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        wcfg_q <= cfg_data_i[WCFG_W-1:0];
      end else begin
        hcfg_q <= cfg_data_i[HCFG_W-1:0];
      end
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_int_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s1_int_q <= accept & interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= gray_pixel_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q - 1'b1;
      s1_ccol_q <= col_ext[COL_OUT_W-1:0];
      s1_last_q <= col_last & row_last;
    end
  end

  pem_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign up  = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_vld_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up;
      win_q[4] <= mid;
      win_q[5] <= s1_pix_q;
    end
  end

  always_comb begin
    sum_top   = (PIX_W+2)'(win_q[0]) + (PIX_W+2)'(win_q[3]) + (PIX_W+2)'(up);
    sum_bot   = (PIX_W+2)'(win_q[2]) + (PIX_W+2)'(win_q[5]) + (PIX_W+2)'(s1_pix_q);
    sum_left  = (PIX_W+2)'(win_q[0]) + (PIX_W+2)'(win_q[1]) + (PIX_W+2)'(win_q[2]);
    sum_right = (PIX_W+2)'(up) + (PIX_W+2)'(mid) + (PIX_W+2)'(s1_pix_q);
    gv = signed'({1'b0, sum_bot}) - signed'({1'b0, sum_top});
    gh = signed'({1'b0, sum_right}) - signed'({1'b0, sum_left});
    av = gv[PIX_W+2] ? GRAD_W'(-gv) : GRAD_W'(gv);
    ah = gh[PIX_W+2] ? GRAD_W'(-gh) : GRAD_W'(gh);
  end

  always_ff @(posedge clk_i) begin
    if (s1_int_q) begin
      m_row_q  <= s1_row_q;
      m_col_q  <= s1_ccol_q;
      m_last_q <= s1_last_q;
    end
  end

  assign out_load      = sq_status.done & (~out_vld_q | ~out_stall_i);
  assign sq_ctrl.start = s1_int_q;
  assign sq_ctrl.take  = out_load;

  pem_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sq_ctrl),
    .av_i     (av),
    .ah_i     (ah),
    .status_o (sq_status),
    .edge_o   (sq_edge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_edge_q <= sq_edge;
      out_row_q  <= m_row_q;
      out_col_q  <= m_col_q;
      out_last_q <= m_last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign edge_value_o = out_edge_q;
  assign center_row_o = out_row_q;
  assign center_col_o = out_col_q;
  assign frame_last_o = out_last_q;

endmodule

`default_nettype wire
